/* sv/pagg_pkg.sv */
// ----------------------------------------------------------------------------
// Period aggregator package
// Shared sizes, mode codes, state types, the command passed from the front
// end to the back end, and the 48-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pagg_pkg;

  localparam int SLOT_COUNT  = 256;
  localparam int MAX_STEPS   = 1024;

  localparam int SLOT_AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int STEP_W      = $clog2(MAX_STEPS + 1);

  localparam int SLOT_IN_W   = 8;
  localparam int MODE_W      = 3;
  localparam int SAMPLE_W    = 32;
  localparam int WEIGHT_W    = 17;
  localparam int VAL_W       = 48;
  localparam int STEPS_OUT_W = 11;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;
  localparam int PART_W      = PROD_W - FRAC_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int SLOT_IN_N   = 2 ** SLOT_IN_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_END   = 3'd0,
    MODE_BEGIN = 3'd1,
    MODE_SUM   = 3'd2,
    MODE_AVG   = 3'd3,
    MODE_MAX   = 3'd4,
    MODE_MIN   = 3'd5
  } agg_mode_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CALC,
    B_DSTART,
    B_DWAIT,
    B_DONE
  } back_state_t;

  typedef logic [SLOT_AW-1:0] slot_idx_t;
  typedef logic [SLOT_AW-1:0] slot_map_t [SLOT_IN_N];

  typedef struct packed {
    slot_idx_t                 slot;
    agg_mode_t                 mode;
    logic                      first;
    logic                      period_end;
    logic signed [VAL_W-1:0]   value;
    logic [STEP_W-1:0]         steps;
  } agg_cmd_t;

  function automatic slot_map_t build_slot_map();
    slot_map_t m;
    for (int i = 0; i < SLOT_IN_N; i++) begin
      m[i] = SLOT_AW'(i % SLOT_COUNT);
    end
    return m;
  endfunction

  // input slot number to accumulator index, wrapped by the slot count
  localparam slot_map_t SLOT_MAP = build_slot_map();

  // clamp a one-bit-grown sum to the signed 48-bit range
  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[VAL_W] != v[VAL_W-1]) begin
      r = {v[VAL_W], {(VAL_W-1){~v[VAL_W]}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/period_aggregator_min_max_sum_avg_top.sv */
// ----------------------------------------------------------------------------
// Period aggregator (last, first, sum, average, maximum, minimum)
// Per-slot accumulation of samples over a period, with weighted cell parts
// and saturated 48-bit results reported at period end.
//
//   Channel  Handshake     Payload
//   input    push / full   in_new_step, in_period_end, in_slot, in_agg_mode,
//                          in_cell_domain, in_sample_value, in_weight,
//                          in_last_part
//   result   empty / pop   out_slot, out_period_value, out_steps_in_period
//
// Front end: a plain sample goes straight to the push state, a cell part passes
// the multiply state first; a two-entry command queue follows it.
// Back end works on each element by accumulator RAM read, combine and write;
// an average at period end also passes through the bit-serial divider.
// Reset clears control state only; accumulator contents are undefined until
// written and need no clearing pass.
// full stays high while the front end works on an item, also while it waits for
// room in the queue; the back end holds a period-end element while the result
// register is occupied and not popped.
`default_nettype none

module period_aggregator_min_max_sum_avg_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic                                 in_new_step,
  input  wire logic                                 in_period_end,
  input  wire logic [pagg_pkg::SLOT_IN_W-1:0]       in_slot,
  input  wire logic [pagg_pkg::MODE_W-1:0]          in_agg_mode,
  input  wire logic                                 in_cell_domain,
  input  wire logic signed [pagg_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic [pagg_pkg::WEIGHT_W-1:0]        in_weight,
  input  wire logic                                 in_last_part,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [pagg_pkg::SLOT_IN_W-1:0]            out_slot,
  output logic signed [pagg_pkg::VAL_W-1:0]         out_period_value,
  output logic [pagg_pkg::STEPS_OUT_W-1:0]          out_steps_in_period
);
  import pagg_pkg::*;

  agg_cmd_t q_wr_cmd;
  agg_cmd_t q_rd_cmd;
  logic     q_push, q_full;
  logic     q_pop, q_empty;

  pagg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_new_step     (in_new_step),
    .in_period_end   (in_period_end),
    .in_slot         (in_slot),
    .in_agg_mode     (in_agg_mode),
    .in_cell_domain  (in_cell_domain),
    .in_sample_value (in_sample_value),
    .in_weight       (in_weight),
    .in_last_part    (in_last_part),
    .q_push          (q_push),
    .q_full          (q_full),
    .q_cmd           (q_wr_cmd)
  );

  pagg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_cmd),
    .empty   (q_empty)
  );

  pagg_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_empty           (q_empty),
    .cmd_pop             (q_pop),
    .cmd                 (q_rd_cmd),
    .pop                 (pop),
    .empty               (empty),
    .out_slot            (out_slot),
    .out_period_value    (out_period_value),
    .out_steps_in_period (out_steps_in_period)
  );

endmodule

`default_nettype wire

/* sv/pagg_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pagg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/pagg_div.sv */
// ----------------------------------------------------------------------------
// Average divider
// Signed 48-bit value divided by the step count, one quotient bit a cycle,
// truncating toward zero. A zero count divides by one.
// ----------------------------------------------------------------------------
`default_nettype none

module pagg_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [pagg_pkg::VAL_W-1:0] dividend,
  input  wire logic [pagg_pkg::STEP_W-1:0]       divisor,
  output logic                                   done,
  output logic signed [pagg_pkg::VAL_W-1:0]      quotient
);
  import pagg_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  q_r, q_nxt;
  logic [STEP_W:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0] den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W:0]   rem_sh;
  logic              fits;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[STEP_W-1:0], q_r[VAL_W-1]};
    fits     = (rem_sh >= {1'b0, den_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = dividend[VAL_W-1];
      q_nxt    = dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
      den_nxt  = (divisor == '0) ? STEP_W'(1) : divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, den_r}) : rem_sh;
      q_nxt   = {q_r[VAL_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

`default_nettype wire

/* sv/pagg_queue.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pagg_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_en,
  input  wire pagg_pkg::agg_cmd_t wr_data,
  output logic                    full,
  input  wire logic               rd_en,
  output pagg_pkg::agg_cmd_t      rd_data,
  output logic                    empty
);
  import pagg_pkg::*;

  agg_cmd_t              entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr_r, wptr_nxt;
  logic [QUEUE_AW-1:0]   rptr_r, rptr_nxt;
  logic [QUEUE_AW:0]     count_r, count_nxt;
  logic                  do_wr, do_rd;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + QUEUE_AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + QUEUE_AW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (QUEUE_AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_wr) begin
      entries_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* sv/pagg_front.sv */
// ----------------------------------------------------------------------------
// Period aggregator front end
// Accepts items, keeps the step count and period flag, folds weighted cell
// parts into the scratch register and queues one command per element.
// ----------------------------------------------------------------------------
`default_nettype none

module pagg_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                push,
  output logic                                     full,
  input  wire logic                                in_new_step,
  input  wire logic                                in_period_end,
  input  wire logic [pagg_pkg::SLOT_IN_W-1:0]      in_slot,
  input  wire logic [pagg_pkg::MODE_W-1:0]         in_agg_mode,
  input  wire logic                                in_cell_domain,
  input  wire logic signed [pagg_pkg::SAMPLE_W-1:0] in_sample_value,
  input  wire logic [pagg_pkg::WEIGHT_W-1:0]       in_weight,
  input  wire logic                                in_last_part,
  output logic                                     q_push,
  input  wire logic                                q_full,
  output pagg_pkg::agg_cmd_t                       q_cmd
);
  import pagg_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2 ** (FRAC_W - 1));

  front_state_t               state_r, state_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       closed_r;
  logic signed [VAL_W-1:0]    scratch_r, scratch_nxt;
  logic signed [PROD_W-1:0]   prod_r;

  slot_idx_t                  slot_r;
  agg_mode_t                  mode_r;
  logic                       pe_r, cell_r, last_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [WEIGHT_W-1:0]        weight_r;

  logic                       accept;
  logic                       scratch_upd;
  logic signed [PART_W-1:0]   part;
  logic signed [VAL_W:0]      sum_w;
  logic signed [VAL_W-1:0]    total;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (push) begin
          state_nxt = in_cell_domain ? F_MUL : F_PUSH;
        end
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if ((cell_r && !last_r) || !q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    full        = 1'b1;
    q_push      = 1'b0;
    scratch_upd = 1'b0;
    case (state_r)
      F_IDLE: begin
        full = 1'b0;
      end
      F_MUL: begin
        full = 1'b1;
      end
      F_PUSH: begin
        q_push      = (!cell_r || last_r) && !q_full;
        scratch_upd = cell_r && (!last_r || !q_full);
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  assign accept = push && !full;

  // step count: restart after a closed period, else count up to the limit
  always_comb begin
    step_nxt = step_r;
    if (accept && in_new_step) begin
      if (closed_r) begin
        step_nxt = STEP_W'(1);
      end else if (step_r < STEP_W'(MAX_STEPS)) begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  assign part  = prod_r[PROD_W-1:FRAC_W];
  assign sum_w = (VAL_W+1)'(scratch_r) + (VAL_W+1)'(part);
  assign total = sat_val(sum_w);

  // a last part clears the scratch, other parts hold the running total
  always_comb begin
    scratch_nxt = scratch_r;
    if (scratch_upd) begin
      scratch_nxt = last_r ? '0 : total;
    end
  end

  always_comb begin
    q_cmd.slot       = slot_r;
    q_cmd.mode       = mode_r;
    q_cmd.first      = (step_r == STEP_W'(1));
    q_cmd.period_end = pe_r;
    q_cmd.value      = cell_r ? total : VAL_W'(sample_r);
    q_cmd.steps      = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      step_r    <= '0;
      closed_r  <= 1'b0;
      scratch_r <= '0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      scratch_r <= scratch_nxt;
      if (accept) begin
        closed_r <= in_period_end;
      end
    end
    if (accept) begin
      slot_r   <= SLOT_MAP[in_slot];
      mode_r   <= agg_mode_t'(in_agg_mode);
      pe_r     <= in_period_end;
      cell_r   <= in_cell_domain;
      sample_r <= in_sample_value;
      weight_r <= in_weight;
      last_r   <= in_last_part;
    end
    if (state_r == F_MUL) begin
      prod_r <= (PROD_W'(sample_r) * PROD_W'($signed({1'b0, weight_r}))) + ROUND_HALF;
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_W'(MAX_STEPS))
    else $error("step count above its limit");

  a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_new_step && closed_r |=> step_r == STEP_W'(1))
    else $error("step count did not restart after a closed period");

  a_closed_track: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> closed_r == $past(in_period_end))
    else $error("period flag does not follow the last item");

endmodule

`default_nettype wire

/* sv/pagg_back.sv */
// ----------------------------------------------------------------------------
// Period aggregator back end
// Read-modify-write of one accumulator per command, average division at
// period end, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pagg_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cmd_empty,
  output logic                                     cmd_pop,
  input  wire pagg_pkg::agg_cmd_t                  cmd,
  input  wire logic                                pop,
  output logic                                     empty,
  output logic [pagg_pkg::SLOT_IN_W-1:0]           out_slot,
  output logic signed [pagg_pkg::VAL_W-1:0]        out_period_value,
  output logic [pagg_pkg::STEPS_OUT_W-1:0]         out_steps_in_period
);
  import pagg_pkg::*;

  back_state_t             state_r, state_nxt;
  agg_cmd_t                cmd_r;
  logic signed [VAL_W-1:0] acc_r;
  logic signed [VAL_W-1:0] acc_nxt;
  logic signed [VAL_W-1:0] ram_q;
  logic [VAL_W-1:0]        ram_rdata;

  logic                    ram_re, ram_we;
  logic                    div_start, div_done;
  logic signed [VAL_W-1:0] div_q;
  logic                    out_ok, out_load;
  logic                    avg_end;

  logic                    out_valid_r;
  logic [SLOT_IN_W-1:0]    out_slot_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [STEPS_OUT_W-1:0]  out_steps_r;

  pagg_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOT_COUNT)
  ) u_acc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd_r.slot),
    .wdata (acc_r),
    .re    (ram_re),
    .raddr (cmd.slot),
    .rdata (ram_rdata)
  );

  pagg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (cmd_r.steps),
    .done     (div_done),
    .quotient (div_q)
  );

  assign ram_q   = $signed(ram_rdata);
  assign avg_end = cmd_r.period_end && (cmd_r.mode == MODE_AVG);
  assign out_ok  = !cmd_r.period_end || !out_valid_r || pop;

  // combine the stored value with the new one
  always_comb begin
    acc_nxt = ram_q;
    case (cmd_r.mode)
      MODE_END: begin
        if (cmd_r.first || cmd_r.period_end) begin
          acc_nxt = cmd_r.value;
        end
      end
      MODE_BEGIN: begin
        if (cmd_r.first) begin
          acc_nxt = cmd_r.value;
        end
      end
      MODE_SUM, MODE_AVG: begin
        acc_nxt = cmd_r.first ? cmd_r.value
                              : sat_val((VAL_W+1)'(ram_q) + (VAL_W+1)'(cmd_r.value));
      end
      MODE_MAX: begin
        if (cmd_r.first || (cmd_r.value > ram_q)) begin
          acc_nxt = cmd_r.value;
        end
      end
      MODE_MIN: begin
        if (cmd_r.first || (cmd_r.value < ram_q)) begin
          acc_nxt = cmd_r.value;
        end
      end
      default: begin
        acc_nxt = ram_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          state_nxt = B_CALC;
        end
      end
      B_CALC: begin
        state_nxt = avg_end ? B_DSTART : B_DONE;
      end
      B_DSTART: begin
        state_nxt = B_DWAIT;
      end
      B_DWAIT: begin
        if (div_done) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_ok) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      B_IDLE: begin
        cmd_pop = !cmd_empty;
        ram_re  = !cmd_empty;
      end
      B_CALC: begin
        ram_re = 1'b0;
      end
      B_DSTART: begin
        div_start = 1'b1;
      end
      B_DWAIT: begin
        div_start = 1'b0;
      end
      B_DONE: begin
        ram_we   = out_ok;
        out_load = out_ok && cmd_r.period_end;
      end
      default: begin
        cmd_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (state_r == B_CALC) begin
      acc_r <= acc_nxt;
    end else if ((state_r == B_DWAIT) && div_done) begin
      acc_r <= div_q;
    end
    if (out_load) begin
      out_slot_r  <= SLOT_IN_W'(cmd_r.slot);
      out_value_r <= acc_r;
      out_steps_r <= STEPS_OUT_W'(cmd_r.steps);
    end
  end

  assign empty               = !out_valid_r;
  assign out_slot            = out_slot_r;
  assign out_period_value    = out_value_r;
  assign out_steps_in_period = out_steps_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || pop))
    else $error("result register overwritten before it was taken");

  a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && cmd_r.period_end |-> out_load)
    else $error("period end written back without a result");

endmodule

`default_nettype wire
